FILE: src/dpd_pkg.sv
// package for the delimited packet deframer
// byte codes, result kinds, error codes, state and result types
// no dependencies
package dpd_pkg;

  localparam logic [7:0] ChHash     = 8'h23;
  localparam logic [7:0] ChLBracket = 8'h5b;
  localparam logic [7:0] ChRBracket = 8'h5d;
  localparam logic [7:0] ChBar      = 8'h7c;
  localparam logic [7:0] ChCr       = 8'h0d;
  localparam logic [7:0] ChLf       = 8'h0a;
  localparam logic [3:0] NibbleMask = 4'hf;

  localparam logic [1:0] KindData  = 2'd0;
  localparam logic [1:0] KindStart = 2'd1;
  localparam logic [1:0] KindEnd   = 2'd2;

  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrPutFull = 2'd1;
  localparam logic [1:0] ErrReject  = 2'd2;

  localparam logic [3:0] RemoteReset = 4'hf;
  localparam int unsigned MaxResults = 4;

  typedef struct packed {
    logic       in_data;
    logic [1:0] match;
    logic [3:0] remote;
    logic [1:0] err;
  } state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
  } entry_t;

  typedef struct packed {
    entry_t [MaxResults-1:0] ent;
    logic [2:0]              num;
  } step_out_t;

  function automatic logic [7:0] term_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = ChHash;
      2'd1:    b = ChBar;
      2'd2:    b = ChCr;
      default: b = ChLf;
    endcase
    return b;
  endfunction

endpackage

FILE: src/delimited_packet_deframer.sv
// delimited packet deframer, top level: input transfer, result buffer, config
// latency: first result of a byte is valid the cycle after its transfer
// throughput: one byte per cycle while each byte gives at most one result and
// ready is high; otherwise the next transfer waits for the last result of the
// four-entry result buffer, which drains one result per cycle when ready is high
// reset: asynchronous, clears state, own channel and result count; remote channel 15
module delimited_packet_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_own_channel_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic [2:0] sink_free_i,
  input  logic       clear_error_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] value_o,
  output logic       last_o,
  output logic [1:0] error_code_o
);

  dpd_pkg::state_t    state_q, state_d;
  dpd_pkg::step_out_t res;
  dpd_pkg::entry_t [dpd_pkg::MaxResults-1:0] ent_q;
  logic [3:0] own_q;
  logic [2:0] rem_q, rem_d;
  logic [1:0] pos_q, pos_d;
  logic       in_xfer, out_xfer;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (rem_q != 3'd0);
  assign out_xfer    = out_valid_o && out_ready_i;
  assign in_ready_o  = (rem_q == 3'd0) || (rem_q == 3'd1 && out_ready_i);
  assign in_xfer     = in_valid_i && in_ready_o;

  dpd_step u_step (
    .rx_byte_i     (rx_byte_i),
    .sink_free_i   (sink_free_i),
    .clear_error_i (clear_error_i),
    .own_channel_i (own_q),
    .state_i       (state_q),
    .state_o       (state_d),
    .res_o         (res)
  );

  always_comb begin
    rem_d = rem_q;
    pos_d = pos_q;
    if (in_xfer) begin
      rem_d = res.num;
      pos_d = 2'd0;
    end else if (out_xfer) begin
      rem_d = rem_q - 3'd1;
      pos_d = pos_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{in_data: 1'b0, match: 2'd0, remote: dpd_pkg::RemoteReset,
                   err: dpd_pkg::ErrNone};
      own_q   <= 4'h0;
      rem_q   <= 3'd0;
      pos_q   <= 2'd0;
    end else begin
      if (in_xfer) begin
        state_q <= state_d;
      end
      if (cfg_valid_i) begin
        own_q <= cfg_own_channel_i;
      end
      rem_q <= rem_d;
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ent_q <= res.ent;
    end
  end

  assign kind_o       = ent_q[pos_q].kind;
  assign value_o      = ent_q[pos_q].value;
  assign last_o       = (rem_q == 3'd1);
  assign error_code_o = state_q.err;

endmodule

FILE: src/dpd_step.sv
// per-byte next state and result list of the deframer
// header hunt, terminator match, replay and rejection
// depends on dpd_pkg
module dpd_step (
  input  logic [7:0]         rx_byte_i,
  input  logic [2:0]         sink_free_i,
  input  logic               clear_error_i,
  input  logic [3:0]         own_channel_i,
  input  dpd_pkg::state_t    state_i,
  output dpd_pkg::state_t    state_o,
  output dpd_pkg::step_out_t res_o
);

  logic [2:0] puts;
  logic       reject;
  logic [2:0] ndata;
  logic       is_hash;

  assign is_hash = (rx_byte_i == dpd_pkg::ChHash);
  assign puts    = {1'b0, state_i.match} + {2'b00, !is_hash};

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    reject  = 1'b0;
    ndata   = 3'd0;
    if (clear_error_i) begin
      state_o.err = dpd_pkg::ErrNone;
    end
    if (state_i.in_data && sink_free_i == 3'd0) begin
      state_o.err = dpd_pkg::ErrPutFull;
    end
    if (!state_i.in_data) begin
      if (state_i.match == 2'd2 &&
          (rx_byte_i[3:0] & dpd_pkg::NibbleMask) == own_channel_i) begin
        state_o.match  = 2'd3;
        state_o.remote = rx_byte_i[7:4];
      end else if (state_i.match == 2'd0 && is_hash) begin
        state_o.match = 2'd1;
      end else if (state_i.match == 2'd1 && rx_byte_i == dpd_pkg::ChLBracket) begin
        state_o.match = 2'd2;
      end else if (state_i.match == 2'd3 && rx_byte_i == dpd_pkg::ChRBracket) begin
        state_o.in_data    = 1'b1;
        state_o.match      = 2'd0;
        res_o.num          = 3'd1;
        res_o.ent[0].kind  = dpd_pkg::KindStart;
        res_o.ent[0].value = {4'h0, state_i.remote};
      end else begin
        state_o.match = is_hash ? 2'd1 : 2'd0;
      end
    end else if (rx_byte_i == dpd_pkg::term_byte(state_i.match)) begin
      if (state_i.match == 2'd3) begin
        state_o.in_data    = 1'b0;
        state_o.match      = 2'd0;
        res_o.num          = 3'd1;
        res_o.ent[0].kind  = dpd_pkg::KindEnd;
        res_o.ent[0].value = 8'h00;
      end else begin
        state_o.match = state_i.match + 2'd1;
      end
    end else begin
      // replay of the partial terminator, then the byte itself unless it is a hash
      reject = (sink_free_i < puts);
      ndata  = reject ? sink_free_i : puts;
      for (int j = 0; j < dpd_pkg::MaxResults; j++) begin
        if (3'(j) < ndata) begin
          res_o.ent[j].kind  = dpd_pkg::KindData;
          res_o.ent[j].value = (3'(j) < {1'b0, state_i.match}) ?
                               dpd_pkg::term_byte(2'(j)) : rx_byte_i;
        end else if (reject && 3'(j) == ndata) begin
          res_o.ent[j].kind  = dpd_pkg::KindEnd;
          res_o.ent[j].value = 8'h00;
        end
      end
      if (reject) begin
        res_o.num       = ndata + 3'd1;
        state_o.err     = dpd_pkg::ErrReject;
        state_o.in_data = 1'b0;
        state_o.match   = 2'd0;
      end else begin
        res_o.num     = ndata;
        state_o.match = is_hash ? 2'd1 : 2'd0;
      end
    end
  end

endmodule

FILE: src/dpd_checker.sv
// port-level checks for the delimited packet deframer
// bound to delimited_packet_deframer; depends on dpd_pkg
module dpd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] kind_o,
  input logic [7:0] value_o,
  input logic       last_o,
  input logic [1:0] error_code_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
    $stable(value_o) && $stable(last_o) && $stable(error_code_o))
    else $error("stalled result changed");

  // input held off only while results are pending
  a_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty result buffer");

  // packet start is alone and carries a nibble
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == dpd_pkg::KindStart |-> last_o && value_o[7:4] == 4'h0)
    else $error("bad packet start result");

  // packet end closes the byte and carries zero
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == dpd_pkg::KindEnd |-> last_o && value_o == 8'h00)
    else $error("bad packet end result");

  a_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> kind_o <= dpd_pkg::KindEnd && error_code_o <= dpd_pkg::ErrReject)
    else $error("undefined kind or error code");

endmodule

bind delimited_packet_deframer dpd_checker u_dpd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .kind_o       (kind_o),
  .value_o      (value_o),
  .last_o       (last_o),
  .error_code_o (error_code_o)
);

FILE: tb/tb_delimited_packet_deframer.sv
// testbench for delimited_packet_deframer: directed table then random packet traffic; results
// checked against the table where a row is typed in, else against a cycle-free deframing predictor
// depends on dpd_pkg and delimited_packet_deframer
`timescale 1ns / 1ps

module tb_delimited_packet_deframer;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
    logic [1:0] err;
  } deframed_t;

  // one received byte; kind/value/err are typed in only when typed is set
  typedef struct packed {
    logic [7:0] b;
    logic [2:0] free;
    logic       clr;
    logic       typed;
    logic       one_res;
    logic [1:0] kind;
    logic [7:0] value;
    logic [1:0] err;
  } row_t;

  localparam logic [3:0][7:0] TermSeq = {dpd_pkg::ChLf, dpd_pkg::ChCr, dpd_pkg::ChBar,
                                         dpd_pkg::ChHash};
  localparam int NumDirected = 25;
  localparam int ItemsPerPhase = 88;

  localparam row_t [0:NumDirected-1] DirRows = {
    {dpd_pkg::ChHash,     3'd4, 1'b0, 1'b1, 1'b0, dpd_pkg::KindData,  8'h00, dpd_pkg::ErrNone},
    {dpd_pkg::ChLBracket, 3'd4, 1'b0, 1'b1, 1'b0, dpd_pkg::KindData,  8'h00, dpd_pkg::ErrNone},
    {8'hf0,               3'd4, 1'b0, 1'b1, 1'b0, dpd_pkg::KindData,  8'h00, dpd_pkg::ErrNone},
    {dpd_pkg::ChRBracket, 3'd4, 1'b0, 1'b1, 1'b1, dpd_pkg::KindStart, 8'h0f, dpd_pkg::ErrNone},
    {8'h00,               3'd4, 1'b0, 1'b1, 1'b1, dpd_pkg::KindData,  8'h00, dpd_pkg::ErrNone},
    {8'hff,               3'd4, 1'b0, 1'b1, 1'b1, dpd_pkg::KindData,  8'hff, dpd_pkg::ErrNone},
    {8'h41,               3'd0, 1'b0, 1'b1, 1'b1, dpd_pkg::KindEnd,   8'h00, dpd_pkg::ErrReject},
    {dpd_pkg::ChHash,     3'd7, 1'b1, 1'b1, 1'b0, dpd_pkg::KindData,  8'h00, dpd_pkg::ErrNone},
    {dpd_pkg::ChLBracket, 3'd5, 1'b0, 1'b1, 1'b0, dpd_pkg::KindData,  8'h00, dpd_pkg::ErrNone},
    {8'h31,               3'd6, 1'b0, 1'b1, 1'b0, dpd_pkg::KindData,  8'h00, dpd_pkg::ErrNone},
    {dpd_pkg::ChHash,     3'd4, 1'b0, 1'b1, 1'b0, dpd_pkg::KindData,  8'h00, dpd_pkg::ErrNone},
    {dpd_pkg::ChLBracket, 3'd4, 1'b0, 1'b1, 1'b0, dpd_pkg::KindData,  8'h00, dpd_pkg::ErrNone},
    {8'h30,               3'd4, 1'b0, 1'b1, 1'b0, dpd_pkg::KindData,  8'h00, dpd_pkg::ErrNone},
    {dpd_pkg::ChRBracket, 3'd4, 1'b0, 1'b1, 1'b1, dpd_pkg::KindStart, 8'h03, dpd_pkg::ErrNone},
    {dpd_pkg::ChHash,     3'd4, 1'b0, 1'b1, 1'b0, dpd_pkg::KindData,  8'h00, dpd_pkg::ErrNone},
    {dpd_pkg::ChBar,      3'd4, 1'b0, 1'b1, 1'b0, dpd_pkg::KindData,  8'h00, dpd_pkg::ErrNone},
    {dpd_pkg::ChCr,       3'd4, 1'b0, 1'b1, 1'b0, dpd_pkg::KindData,  8'h00, dpd_pkg::ErrNone},
    {8'h78,               3'd4, 1'b0, 1'b0, 1'b0, dpd_pkg::KindData,  8'h00, dpd_pkg::ErrNone},
    {dpd_pkg::ChHash,     3'd0, 1'b0, 1'b1, 1'b0, dpd_pkg::KindData,  8'h00, dpd_pkg::ErrNone},
    {dpd_pkg::ChHash,     3'd1, 1'b0, 1'b0, 1'b0, dpd_pkg::KindData,  8'h00, dpd_pkg::ErrNone},
    {8'h55,               3'd4, 1'b1, 1'b0, 1'b0, dpd_pkg::KindData,  8'h00, dpd_pkg::ErrNone},
    {dpd_pkg::ChHash,     3'd4, 1'b0, 1'b1, 1'b0, dpd_pkg::KindData,  8'h00, dpd_pkg::ErrNone},
    {dpd_pkg::ChBar,      3'd4, 1'b0, 1'b1, 1'b0, dpd_pkg::KindData,  8'h00, dpd_pkg::ErrNone},
    {dpd_pkg::ChCr,       3'd4, 1'b0, 1'b1, 1'b0, dpd_pkg::KindData,  8'h00, dpd_pkg::ErrNone},
    {dpd_pkg::ChLf,       3'd4, 1'b0, 1'b1, 1'b1, dpd_pkg::KindEnd,   8'h00, dpd_pkg::ErrNone}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_own = 4'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'd0;
  logic [2:0] sink_free = 3'd0;
  logic       clear_error = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] kind;
  logic [7:0] value;
  logic       last;
  logic [1:0] error_code;

  int send_idle = 30;
  int recv_idle = 71;
  int errors = 0;
  int rand_items = 0;

  // deframer state as the predictor sees it
  logic       m_in_data = 1'b0;
  logic [1:0] m_match = 2'd0;
  logic [3:0] m_remote = dpd_pkg::RemoteReset;
  logic [1:0] m_err = dpd_pkg::ErrNone;
  logic [3:0] m_own = 4'd0;

  deframed_t step_q[$];
  deframed_t deframed_q[$];

  delimited_packet_deframer dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_own_channel_i(cfg_own),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .rx_byte_i        (rx_byte),
    .sink_free_i      (sink_free),
    .clear_error_i    (clear_error),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .kind_o           (kind),
    .value_o          (value),
    .last_o           (last),
    .error_code_o     (error_code)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void push_step(input logic [1:0] k, input logic [7:0] v);
    deframed_t r;
    r.kind = k;
    r.value = v;
    r.last = 1'b0;
    r.err = dpd_pkg::ErrNone;
    step_q.push_back(r);
  endfunction

  function automatic void deframe_byte(input logic [7:0] b, input logic [2:0] free,
                                       input logic clr);
    int unsigned room;
    logic ok;
    int i;
    step_q.delete();
    room = free;
    if (clr) m_err = dpd_pkg::ErrNone;
    if (m_in_data && free == 3'd0) m_err = dpd_pkg::ErrPutFull;
    if (!m_in_data) begin
      if (m_match == 2'd2 && b[3:0] == m_own) begin
        m_match = 2'd3;
        m_remote = b[7:4];
      end else if (m_match == 2'd0 && b == dpd_pkg::ChHash) begin
        m_match = 2'd1;
      end else if (m_match == 2'd1 && b == dpd_pkg::ChLBracket) begin
        m_match = 2'd2;
      end else if (m_match == 2'd3 && b == dpd_pkg::ChRBracket) begin
        m_in_data = 1'b1;
        m_match = 2'd0;
        push_step(dpd_pkg::KindStart, {4'd0, m_remote});
      end else begin
        m_match = (b == dpd_pkg::ChHash) ? 2'd1 : 2'd0;
      end
    end else if (b == TermSeq[m_match]) begin
      if (m_match == 2'd3) begin
        m_in_data = 1'b0;
        m_match = 2'd0;
        push_step(dpd_pkg::KindEnd, 8'd0);
      end else begin
        m_match = m_match + 2'd1;
      end
    end else begin
      // replay the broken terminator prefix, then the byte itself unless it is a hash
      ok = 1'b1;
      for (i = 0; i < m_match && ok; i++) begin
        if (room == 0) begin
          ok = 1'b0;
        end else begin
          room--;
          push_step(dpd_pkg::KindData, TermSeq[i]);
        end
      end
      if (ok && b != dpd_pkg::ChHash) begin
        if (room == 0) begin
          ok = 1'b0;
        end else begin
          room--;
          push_step(dpd_pkg::KindData, b);
        end
      end
      if (!ok) begin
        m_err = dpd_pkg::ErrReject;
        m_in_data = 1'b0;
        m_match = 2'd0;
        push_step(dpd_pkg::KindEnd, 8'd0);
      end else begin
        m_match = (b == dpd_pkg::ChHash) ? 2'd1 : 2'd0;
      end
    end
    foreach (step_q[j]) begin
      step_q[j].last = (j == step_q.size() - 1);
      step_q[j].err = m_err;
    end
  endfunction

  task automatic send_byte(input row_t row);
    deframed_t want;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= row.b;
    sink_free <= row.free;
    clear_error <= row.clr;
    do @(posedge clk); while (!in_ready);
    deframe_byte(row.b, row.free, row.clr);
    if (row.typed) begin
      if (row.one_res) begin
        want.kind = row.kind;
        want.value = row.value;
        want.last = 1'b1;
        want.err = row.err;
        deframed_q.push_back(want);
      end
    end else begin
      foreach (step_q[j]) deframed_q.push_back(step_q[j]);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_own(input logic [3:0] ch);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_own <= ch;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    m_own = ch;
  endtask

  function automatic row_t rx_row(input logic [7:0] b);
    row_t r;
    int p;
    r = '0;
    r.b = b;
    p = $urandom_range(99);
    if (p < 5) r.free = 3'd0;
    else if (p < 30) r.free = 3'($urandom_range(3, 1));
    else r.free = 3'($urandom_range(7, 4));
    r.clr = ($urandom_range(99) < 8);
    return r;
  endfunction

  task automatic put_rand(input logic [7:0] b);
    send_byte(rx_row(b));
    rand_items++;
  endtask

  task automatic send_packet();
    logic [3:0][7:0] hdr;
    logic [7:0] chan;
    int skip;
    int len;
    int r;
    int pre;
    // line noise while hunting
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(3, 1)) send_byte(rx_row(8'($urandom_range(255))));
    end
    chan = {4'($urandom_range(15)), m_own};
    if ($urandom_range(99) < 10) chan[3:0] = m_own ^ 4'($urandom_range(15, 1));
    hdr = {dpd_pkg::ChRBracket, chan, dpd_pkg::ChLBracket, dpd_pkg::ChHash};
    skip = ($urandom_range(99) < 8) ? $urandom_range(3) : 4;
    for (int k = 0; k < 4; k++) begin
      if (k != skip) put_rand(hdr[k]);
    end
    len = $urandom_range(12);
    for (int k = 0; k < len; k++) begin
      r = $urandom_range(9);
      if (r < 5) begin
        put_rand(8'($urandom_range(255)));
      end else if (r < 9) begin
        put_rand(TermSeq[r-5]);
      end else begin
        pre = $urandom_range(3, 1);
        for (int j = 0; j < pre; j++) put_rand(TermSeq[j]);
      end
    end
    if ($urandom_range(99) < 90) begin
      for (int j = 0; j < 4; j++) put_rand(TermSeq[j]);
    end
    if ($urandom_range(99) < 10) drain_results();
  endtask

  always @(posedge clk) begin : result_check
    deframed_t want;
    if (rst_n && out_valid && out_ready) begin
      if (deframed_q.size() == 0) begin
        $display("%0t: unexpected result kind %0d value %02h last %0d err %0d",
                 $time, kind, value, last, error_code);
        errors++;
      end else begin
        want = deframed_q.pop_front();
        if (kind !== want.kind || value !== want.value || last !== want.last ||
            error_code !== want.err) begin
          $display({"%0t: mismatch expected kind %0d value %02h last %0d err %0d, ",
                    "actual kind %0d value %02h last %0d err %0d"},
                   $time, want.kind, want.value, want.last, want.err,
                   kind, value, last, error_code);
          errors++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < NumDirected; i++) send_byte(DirRows[i]);
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 30;
          recv_idle = 71;
          write_own(4'hf);
        end
        1: begin
          send_idle = 71;
          recv_idle = 30;
          write_own(4'($urandom_range(14, 1)));
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
          write_own(4'h0);
        end
      endcase
      rand_items = 0;
      while (rand_items < ItemsPerPhase) send_packet();
    end
    drain_results();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
